FILE: rtl/core/cbnf_pkg.sv
// Shared types and constants of the contour box nest filter.
package cbnf_pkg;

    // Width of every coordinate field on the ports and of the size register.
    localparam int FIELD_W = 12;

    // Register map (word index) and reset value of the size threshold.
    localparam logic REG_MIN_EXTENT = 1'b0;
    localparam logic [FIELD_W-1:0] MIN_EXTENT_RESET = 12'd9;

    // Entries in the box queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_CHECK,
        BK_DECIDE
    } back_state_t;

endpackage

FILE: rtl/core/contour_box_nest_filter_top.sv
// Contour bounding-box filter: top level with stream ports and register port.
//
// Contour points enter on the s_axis side, one per cycle while the box queue has room.
// Each contour end places its box in a four-entry queue; the back end then fetches it
// (BK_IDLE), compares it against each stored box in turn (BK_READ, then BK_CHECK),
// ending early on the first containing box, and decides (BK_DECIDE). That containment
// scan over the single read port of the kept-box store sets the sustained rate. A result
// waits in an output register while the next boxes are being checked. The store needs no
// clearing after reset; a frame end empties it at once. min_extent sits at byte address 0
// and resets to 9.
module contour_box_nest_filter_top #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // px, py
    input  logic        s_axis_tlast,   // contour_end
    input  logic        s_axis_tuser,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // box_x_start, box_y_start, box_x_end, box_y_end
    output logic        m_axis_tlast,   // last_of_frame
    output logic [1:0]  m_axis_tuser,   // box_kept, store_overflow
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cbnf_pkg::*;

    localparam int DW = 4 * COORD_BITS + 1;

    logic [FIELD_W-1:0] min_extent_reg;
    logic               cfg_write;
    logic               push;
    logic [DW-1:0]      push_data;
    logic               pop;
    logic [DW-1:0]      pop_data;
    q_stat_t            q_stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MIN_EXTENT);
    assign prdata    = (paddr[2] == REG_MIN_EXTENT) ? 32'(min_extent_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_extent_reg <= MIN_EXTENT_RESET;
        end
        else if (cfg_write)
        begin
            min_extent_reg <= pwdata[FIELD_W-1:0];
        end
    end

    cbnf_front #(
        .CW (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .px          (s_axis_tdata[11:0]),
        .py          (s_axis_tdata[23:12]),
        .contour_end (s_axis_tlast),
        .frame_end   (s_axis_tuser),
        .push        (push),
        .push_data   (push_data),
        .q_stat      (q_stat)
    );

    cbnf_queue #(
        .DW (DW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    cbnf_back #(
        .CW        (COORD_BITS),
        .MAX_BOXES (MAX_BOXES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop            (pop),
        .pop_data       (pop_data),
        .q_stat         (q_stat),
        .min_extent     (min_extent_reg),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .box_x_start    (m_axis_tdata[11:0]),
        .box_y_start    (m_axis_tdata[23:12]),
        .box_x_end      (m_axis_tdata[35:24]),
        .box_y_end      (m_axis_tdata[47:36]),
        .box_kept       (m_axis_tuser[0]),
        .last_of_frame  (m_axis_tlast),
        .store_overflow (m_axis_tuser[1])
    );

endmodule

FILE: rtl/core/cbnf_front.sv
// Front end: accepts contour points, tracks running bounds and queues finished boxes.
module cbnf_front #(
    parameter int CW = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cbnf_pkg::FIELD_W-1:0]  px,
    input  logic [cbnf_pkg::FIELD_W-1:0]  py,
    input  logic                          contour_end,
    input  logic                          frame_end,
    output logic                          push,
    output logic [4*CW:0]                 push_data,
    input  cbnf_pkg::q_stat_t             q_stat
);
    import cbnf_pkg::*;

    logic [CW-1:0] x_in;
    logic [CW-1:0] y_in;
    logic [CW-1:0] x_min_reg, x_min_next;
    logic [CW-1:0] x_max_reg, x_max_next;
    logic [CW-1:0] y_min_reg, y_min_next;
    logic [CW-1:0] y_max_reg, y_max_next;
    logic          in_contour_reg, in_contour_next;
    logic          accept;
    logic          ends_contour;

    assign x_in         = CW'(px);
    assign y_in         = CW'(py);
    assign in_ready     = !q_stat.full;
    assign accept       = in_valid && in_ready;
    assign ends_contour = contour_end || frame_end;

    always_comb
    begin
        x_min_next      = x_min_reg;
        x_max_next      = x_max_reg;
        y_min_next      = y_min_reg;
        y_max_next      = y_max_reg;
        in_contour_next = in_contour_reg;
        if (accept)
        begin
            if (!in_contour_reg)
            begin
                x_min_next = x_in;
                x_max_next = x_in;
                y_min_next = y_in;
                y_max_next = y_in;
            end
            else
            begin
                x_min_next = (x_in < x_min_reg) ? x_in : x_min_reg;
                x_max_next = (x_in > x_max_reg) ? x_in : x_max_reg;
                y_min_next = (y_in < y_min_reg) ? y_in : y_min_reg;
                y_max_next = (y_in > y_max_reg) ? y_in : y_max_reg;
            end
            in_contour_next = !ends_contour;
        end
    end

    // The finished box carries the bounds including its last point.
    assign push      = accept && ends_contour;
    assign push_data = {frame_end, y_max_next, x_max_next, y_min_next, x_min_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg      <= '0;
            x_max_reg      <= '0;
            y_min_reg      <= '0;
            y_max_reg      <= '0;
            in_contour_reg <= 1'b0;
        end
        else
        begin
            x_min_reg      <= x_min_next;
            x_max_reg      <= x_max_next;
            y_min_reg      <= y_min_next;
            y_max_reg      <= y_max_next;
            in_contour_reg <= in_contour_next;
        end
    end

endmodule

FILE: rtl/core/cbnf_queue.sv
// Short queue of finished boxes between the front and back ends.
module cbnf_queue #(
    parameter int DW = 49
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DW-1:0]     push_data,
    input  logic              pop,
    output logic [DW-1:0]     pop_data,
    output cbnf_pkg::q_stat_t q_stat
);
    import cbnf_pkg::*;

    logic [DW-1:0]          slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   fill_reg, fill_next;
    logic                   do_push;
    logic                   do_pop;

    assign q_stat.full  = (fill_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign q_stat.empty = (fill_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_data     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/cbnf_back.sv
// Back end: size test, containment scan over the kept-box store and result register.
module cbnf_back #(
    parameter int CW        = 12,
    parameter int MAX_BOXES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    output logic                          pop,
    input  logic [4*CW:0]                 pop_data,
    input  cbnf_pkg::q_stat_t             q_stat,
    input  logic [cbnf_pkg::FIELD_W-1:0]  min_extent,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cbnf_pkg::FIELD_W-1:0]  box_x_start,
    output logic [cbnf_pkg::FIELD_W-1:0]  box_y_start,
    output logic [cbnf_pkg::FIELD_W-1:0]  box_x_end,
    output logic [cbnf_pkg::FIELD_W-1:0]  box_y_end,
    output logic                          box_kept,
    output logic                          last_of_frame,
    output logic                          store_overflow
);
    import cbnf_pkg::*;

    localparam int AW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNTW = $clog2(MAX_BOXES + 1);
    localparam int EW   = (CW > FIELD_W) ? CW : FIELD_W;

    back_state_t     state_reg, state_next;
    logic [4*CW:0]   box_reg, box_next;
    logic            reject_reg, reject_next;
    logic [CNTW-1:0] idx_reg, idx_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic            out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] ox0_reg, oy0_reg, ox1_reg, oy1_reg;
    logic            okept_reg, olast_reg, oovf_reg;
    logic            out_load;

    logic [4*CW-1:0] store_mem [MAX_BOXES];
    logic [4*CW-1:0] store_q_reg;
    logic            store_we;

    logic [CW-1:0]   in_x0, in_y0, in_x1, in_y1;
    logic            size_ok;
    logic [CW-1:0]   cur_x0, cur_y0, cur_x1, cur_y1;
    logic            cur_frame_end;
    logic [CW-1:0]   st_x0, st_y0, st_x1, st_y1;
    logic            contains;
    logic            store_full;
    logic            out_free;

    // Size test on the box at the head of the queue.
    assign in_x0   = pop_data[CW-1:0];
    assign in_y0   = pop_data[2*CW-1:CW];
    assign in_x1   = pop_data[3*CW-1:2*CW];
    assign in_y1   = pop_data[4*CW-1:3*CW];
    assign size_ok = (EW'(in_x1 - in_x0) > EW'(min_extent))
                  && (EW'(in_y1 - in_y0) > EW'(min_extent));

    assign cur_x0        = box_reg[CW-1:0];
    assign cur_y0        = box_reg[2*CW-1:CW];
    assign cur_x1        = box_reg[3*CW-1:2*CW];
    assign cur_y1        = box_reg[4*CW-1:3*CW];
    assign cur_frame_end = box_reg[4*CW];

    assign st_x0    = store_q_reg[CW-1:0];
    assign st_y0    = store_q_reg[2*CW-1:CW];
    assign st_x1    = store_q_reg[3*CW-1:2*CW];
    assign st_y1    = store_q_reg[4*CW-1:3*CW];
    assign contains = (st_x0 <= cur_x0) && (st_y0 <= cur_y0)
                   && (st_x1 >= cur_x1) && (st_y1 >= cur_y1);

    assign store_full = (count_reg == CNTW'(MAX_BOXES));
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        box_next       = box_reg;
        reject_next    = reject_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        pop            = 1'b0;
        out_load       = 1'b0;
        store_we       = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop         = 1'b1;
                    box_next    = pop_data;
                    reject_next = !size_ok;
                    idx_next    = '0;
                    state_next  = (size_ok && (count_reg != '0)) ? BK_READ : BK_DECIDE;
                end
            end
            BK_READ:
            begin
                state_next = BK_CHECK;
            end
            BK_CHECK:
            begin
                if (contains)
                begin
                    reject_next = 1'b1;
                    state_next  = BK_DECIDE;
                end
                else if (idx_reg + 1'b1 == count_reg)
                begin
                    state_next = BK_DECIDE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = BK_READ;
                end
            end
            BK_DECIDE:
            begin
                // A rejected box that does not end the frame leaves no result.
                if (out_free || (reject_reg && !cur_frame_end))
                begin
                    out_load = !reject_reg || cur_frame_end;
                    if (!reject_reg)
                    begin
                        if (store_full)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            store_we   = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    if (cur_frame_end)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            reject_reg    <= 1'b0;
            idx_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            reject_reg    <= reject_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        box_reg <= box_next;
        if (out_load)
        begin
            ox0_reg   <= FIELD_W'(cur_x0);
            oy0_reg   <= FIELD_W'(cur_y0);
            ox1_reg   <= FIELD_W'(cur_x1);
            oy1_reg   <= FIELD_W'(cur_y1);
            okept_reg <= !reject_reg;
            olast_reg <= cur_frame_end;
            // Overflow includes the one caused by this very box.
            oovf_reg  <= ovf_reg || (!reject_reg && store_full);
        end
    end

    // Kept-box store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[count_reg[AW-1:0]] <= box_reg[4*CW-1:0];
        end
        store_q_reg <= store_mem[idx_reg[AW-1:0]];
    end

    assign out_valid      = out_valid_reg;
    assign box_x_start    = ox0_reg;
    assign box_y_start    = oy0_reg;
    assign box_x_end      = ox1_reg;
    assign box_y_end      = oy1_reg;
    assign box_kept       = okept_reg;
    assign last_of_frame  = olast_reg;
    assign store_overflow = oovf_reg;

endmodule
